>>> src/hrt_pkg.sv
// Shared types and constants for the HTTP request header tokenizer.
`default_nettype none

package hrt_pkg;

    // Character codes the tokenizer looks for
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_SP    = 8'h20;
    localparam logic [7:0] BYTE_COLON = 8'h3A;

    // Input command codes (carried on the input tuser)
    localparam logic [1:0] CMD_DATA  = 2'd0;
    localparam logic [1:0] CMD_FLUSH = 2'd1;
    localparam logic [1:0] CMD_NEWCN = 2'd2;

    // Parse mode; code 3 is unused and behaves as body
    localparam logic [1:0] MODE_REQ  = 2'd0;
    localparam logic [1:0] MODE_HDR  = 2'd1;
    localparam logic [1:0] MODE_BODY = 2'd2;

    // Field phase: request line method/path/version, headers key/value
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    // Byte classes
    localparam logic [2:0] CLS_METHOD  = 3'd0;
    localparam logic [2:0] CLS_PATH    = 3'd1;
    localparam logic [2:0] CLS_VERSION = 3'd2;
    localparam logic [2:0] CLS_KEY     = 3'd3;
    localparam logic [2:0] CLS_VALUE   = 3'd4;
    localparam logic [2:0] CLS_DELIM   = 3'd5;
    localparam logic [2:0] CLS_BODY    = 3'd6;

    // Parser context carried from byte to byte
    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] phase;
        logic       cr_before;
        logic       line_has;
        logic       meth_seen;
        logic       path_seen;
        logic       sp_after_colon;
    } t_pstate;

    localparam t_pstate PSTATE_CLEAR = '{
        mode: MODE_REQ, phase: PH_FIRST, cr_before: 1'b0, line_has: 1'b0,
        meth_seen: 1'b0, path_seen: 1'b0, sp_after_colon: 1'b0
    };

    // One classified result word
    typedef struct packed {
        logic       hdr_done;
        logic       req_ok;
        logic       line_end;
        logic [2:0] cls;
        logic [7:0] data;
    } t_result;

endpackage

`default_nettype wire

>>> src/hrt_classify.sv
// Combinational classifier: one held byte plus lookahead gives class and next context.
`default_nettype none

module hrt_classify
    import hrt_pkg::*;
(
    input  wire t_pstate    i_state,
    input  wire logic [7:0] i_byte,
    input  wire logic [7:0] i_next,
    input  wire logic       i_has_next,
    output t_pstate         o_state,
    output t_result         o_result
);

    logic cr_lf_ahead;
    logic colon_sp_ahead;

    assign cr_lf_ahead    = (i_byte == BYTE_CR) && i_has_next && (i_next == BYTE_LF);
    assign colon_sp_ahead = (i_byte == BYTE_COLON) && i_has_next && (i_next == BYTE_SP);

    // Classification and context update
    always_comb begin
        o_state           = i_state;
        o_state.cr_before = 1'b0;
        o_result.data     = i_byte;
        o_result.cls      = CLS_BODY;
        o_result.line_end = 1'b0;
        o_result.req_ok   = 1'b0;
        o_result.hdr_done = 1'b0;

        if (i_state.mode != MODE_REQ && i_state.mode != MODE_HDR) begin
            o_result.cls = CLS_BODY;
        end else if (i_byte == BYTE_LF && i_state.cr_before) begin
            // LF of a CRLF closes the line
            o_result.cls      = CLS_DELIM;
            o_result.line_end = 1'b1;
            if (i_state.mode == MODE_REQ) begin
                o_result.req_ok = (i_state.phase == PH_THIRD) && i_state.meth_seen
                                  && i_state.path_seen;
                o_state.mode    = MODE_HDR;
            end else if (!i_state.line_has) begin
                o_result.hdr_done = 1'b1;
                o_state.mode      = MODE_BODY;
            end
            o_state.phase          = PH_FIRST;
            o_state.line_has       = 1'b0;
            o_state.meth_seen      = 1'b0;
            o_state.path_seen      = 1'b0;
            o_state.sp_after_colon = 1'b0;
        end else if (cr_lf_ahead) begin
            o_result.cls      = CLS_DELIM;
            o_state.cr_before = 1'b1;
        end else begin
            o_state.line_has = 1'b1;
            if (i_state.sp_after_colon && i_byte == BYTE_SP) begin
                // space of the header separator
                o_result.cls           = CLS_DELIM;
                o_state.sp_after_colon = 1'b0;
                o_state.phase          = PH_SECOND;
            end else if (i_state.mode == MODE_REQ) begin
                if (i_byte == BYTE_SP && i_state.phase < PH_THIRD) begin
                    o_result.cls  = CLS_DELIM;
                    o_state.phase = i_state.phase + 2'd1;
                end else if (i_state.phase == PH_FIRST) begin
                    o_result.cls      = CLS_METHOD;
                    o_state.meth_seen = 1'b1;
                end else if (i_state.phase == PH_SECOND) begin
                    o_result.cls      = CLS_PATH;
                    o_state.path_seen = 1'b1;
                end else begin
                    o_result.cls = CLS_VERSION;
                end
            end else if (i_state.phase == PH_FIRST) begin
                if (colon_sp_ahead) begin
                    o_result.cls           = CLS_DELIM;
                    o_state.sp_after_colon = 1'b1;
                end else begin
                    o_result.cls = CLS_KEY;
                end
            end else begin
                o_result.cls = CLS_VALUE;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/http_request_header_tokenizer_core.sv
// Top level of the HTTP request header tokenizer: lookahead register, context and output stage.
//
//  channel  | dir | tdata            | tuser
//  ---------+-----+------------------+--------------------------------------------
//  s (in)   | in  | [7:0] data byte  | [1:0] cmd
//  m (out)  | out | [7:0] out byte   | [2:0] class, [3] line end, [4] request ok,
//           |     |                  | [5] header done
//
//  One word per cycle while s_tready is high: a held byte is classified when the
//  next word is accepted, in the same cycle, and is written to the output register
//  on that acceptance. Throughput is set by the single output register; s_tready
//  follows m_tready while a result is held.
//  Synchronous active-low reset clears the context and empties both registers.
//  A stalled output holds its word; the input stalls only while it is full.
`default_nettype none

module http_request_header_tokenizer_core
    import hrt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  wire logic [1:0] i_s_tuser,   // [1:0] cmd
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] out_byte
    output logic [5:0]      o_m_tuser    // [2:0] byte_class, [3] line_end,
                                         // [4] request_ok, [5] header_done
);

    t_pstate    r_state, n_state;
    t_pstate    cls_state;
    t_result    cls_result;
    t_result    r_out;
    logic [7:0] r_held, n_held;
    logic       r_held_vld, n_held_vld;
    logic       r_m_vld;
    logic       s_acc;
    logic       emit;
    logic       is_data;
    logic       is_flush;

    assign o_s_tready = !r_m_vld || i_m_tready;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign is_data    = (i_s_tuser == CMD_DATA);
    assign is_flush   = (i_s_tuser == CMD_FLUSH) || (i_s_tuser == CMD_NEWCN);
    assign emit       = s_acc && r_held_vld && (is_data || is_flush);

    hrt_classify u_classify (
        .i_state    (r_state),
        .i_byte     (r_held),
        .i_next     (i_s_tdata),
        .i_has_next (is_data),
        .o_state    (cls_state),
        .o_result   (cls_result)
    );

    // Next lookahead and context
    always_comb begin
        n_state    = r_state;
        n_held     = r_held;
        n_held_vld = r_held_vld;
        if (s_acc) begin
            if (emit) begin
                n_state = cls_state;
            end
            if (is_data) begin
                n_held     = i_s_tdata;
                n_held_vld = 1'b1;
            end else if (is_flush) begin
                n_held     = 8'd0;
                n_held_vld = 1'b0;
                if (i_s_tuser == CMD_NEWCN) begin
                    n_state = PSTATE_CLEAR;
                end
            end
        end
    end

    // Context, lookahead and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= PSTATE_CLEAR;
            r_held     <= 8'd0;
            r_held_vld <= 1'b0;
            r_m_vld    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_held     <= n_held;
            r_held_vld <= n_held_vld;
            if (emit) begin
                r_m_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_m_vld <= 1'b0;
            end
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= cls_result;
        end
    end

    assign o_m_tvalid = r_m_vld;
    assign o_m_tdata  = r_out.data;
    assign o_m_tuser  = {r_out.hdr_done, r_out.req_ok, r_out.line_end, r_out.cls};

    // Flags only ride on the LF of a CRLF
    a_flags_on_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_vld && (r_out.hdr_done || r_out.req_ok)) |-> (r_out.line_end &&
        r_out.cls == CLS_DELIM))
        else $error("request_ok or header_done without line end");

    // End of headers moves the parser to body
    a_body_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && cls_result.hdr_done && i_s_tuser != CMD_NEWCN) |=>
        (r_state.mode == MODE_BODY))
        else $error("header_done without entering body mode");

    // Nothing held means no result
    a_no_emit_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && !r_held_vld) |=> !r_m_vld)
        else $error("result produced with no held byte");

    // Body bytes never carry line flags
    a_body_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_vld && r_out.cls == CLS_BODY) |-> !r_out.line_end)
        else $error("body byte flagged as line end");

endmodule

`default_nettype wire
